// ===== design/sme_pkg.sv =====
// Shared types, codes and defaults for the stack machine executor.
package sme_pkg;

	localparam int STACK_DEPTH_DEF  = 64;
	localparam int MEMORY_WORDS_DEF = 16;
	localparam int QUEUE_DEPTH      = 2;
	localparam int WORD_W           = 32;
	localparam int COUNT_W          = 7;
	localparam int SKIP_W           = 31;

	localparam logic [1:0] KIND_EXEC   = 2'd0;
	localparam logic [1:0] KIND_MWRITE = 2'd1;
	localparam logic [1:0] KIND_MREAD  = 2'd2;

	localparam logic [3:0] OPC_ADD   = 4'd0;
	localparam logic [3:0] OPC_NOR   = 4'd1;
	localparam logic [3:0] OPC_IFZ   = 4'd2;
	localparam logic [3:0] OPC_HALT  = 4'd3;
	localparam logic [3:0] OPC_LOAD  = 4'd4;
	localparam logic [3:0] OPC_STORE = 4'd5;
	localparam logic [3:0] OPC_POP   = 4'd6;
	localparam logic [3:0] OPC_PUSHI = 4'd7;
	localparam logic [3:0] OPC_NOOP  = 4'd8;

	localparam logic [2:0] ERR_OK     = 3'd0;
	localparam logic [2:0] ERR_UNDER  = 3'd1;
	localparam logic [2:0] ERR_OVER   = 3'd2;
	localparam logic [2:0] ERR_ADDR   = 3'd3;
	localparam logic [2:0] ERR_HALTED = 3'd4;

	typedef enum logic [3:0] {
		CMD_ADD,
		CMD_NOR,
		CMD_IFZ,
		CMD_HALT,
		CMD_LOAD,
		CMD_STORE,
		CMD_POP,
		CMD_PUSHI,
		CMD_NOOP,
		CMD_MWRITE,
		CMD_MREAD,
		CMD_NONE
	} cmd_op_t;

	typedef enum logic {
		BS_FETCH,
		BS_EXEC
	} back_state_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [3:0]               opcode;
		logic signed [WORD_W-1:0] immediate;
		logic [3:0]               mem_address;
		logic signed [WORD_W-1:0] mem_value;
	} in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] top_value;
		logic [COUNT_W-1:0]       stack_count;
		logic                     is_halted;
		logic                     was_skipped;
		logic [2:0]               error_code;
		logic signed [WORD_W-1:0] read_value;
	} out_t;

	typedef struct packed {
		cmd_op_t                  op;
		logic [WORD_W-1:0]        imm;
		logic [3:0]               addr;
		logic [WORD_W-1:0]        mval;
		logic                     addr_ok;
	} cmd_t;

endpackage

// ===== design/sme_front.sv =====
// Front end: takes instruction transfers, decodes them into commands, feeds the queue.
module sme_front import sme_pkg::*; #(
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic instr_valid,
	output logic instr_stall,
	input  in_t  instr,
	output logic push,
	output cmd_t push_data,
	input  logic q_full
);

	cmd_t s1_q;
	logic s1_valid_q;
	cmd_t dec;
	logic accept;

	always_comb begin
		dec.imm     = instr.immediate;
		dec.addr    = instr.mem_address;
		dec.mval    = instr.mem_value;
		dec.addr_ok = 32'(instr.mem_address) < 32'(MEMORY_WORDS);
		case (instr.kind)
			KIND_EXEC: begin
				case (instr.opcode)
					OPC_ADD:   dec.op = CMD_ADD;
					OPC_NOR:   dec.op = CMD_NOR;
					OPC_IFZ:   dec.op = CMD_IFZ;
					OPC_HALT:  dec.op = CMD_HALT;
					OPC_LOAD:  dec.op = CMD_LOAD;
					OPC_STORE: dec.op = CMD_STORE;
					OPC_POP:   dec.op = CMD_POP;
					OPC_PUSHI: dec.op = CMD_PUSHI;
					default:   dec.op = CMD_NOOP;
				endcase
			end
			KIND_MWRITE: dec.op = CMD_MWRITE;
			KIND_MREAD:  dec.op = CMD_MREAD;
			default:     dec.op = CMD_NONE;
		endcase
	end

	assign instr_stall = s1_valid_q && q_full;
	assign accept      = instr_valid && !instr_stall;
	assign push        = s1_valid_q && !q_full;
	assign push_data   = s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= dec;
		end
	end

endmodule

// ===== design/sme_queue.sv =====
// Small command queue between the front end and the execution back end.
module sme_queue import sme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = count_q == CW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/sme_back.sv =====
// Back end: stack RAM with cached top, data memory; fetches each command, then executes it.
module sme_back import sme_pkg::*; #(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cmd_t head,
	output logic pop,
	output logic result_valid,
	input  logic result_stall,
	output out_t result
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DAW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0] data_mem  [MEMORY_WORDS];

	back_state_t       state_q, state_d;
	cmd_t              cmd_q;
	logic [SPW-1:0]    sp_q, sp_d;
	logic [WORD_W-1:0] top_q, top_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic              halt_q, halt_d;
	logic [WORD_W-1:0] st_rd0_q, st_rd1_q, dm_rd_q;
	out_t              res_q, res_d;
	logic              res_valid_q;

	logic [SPW-1:0]    sp_m1, sp_m2, sp_m3;
	logic [DAW-1:0]    dm_raddr;
	logic              out_free, commit;
	logic              top_ok;
	logic              st_we, dm_we;
	logic [DAW-1:0]    dm_waddr;
	logic [WORD_W-1:0] dm_wdata;
	logic [2:0]        err;
	logic              skipped;
	logic [WORD_W-1:0] rd_val;

	assign sp_m1    = sp_q - SPW'(1);
	assign sp_m2    = sp_q - SPW'(2);
	assign sp_m3    = sp_q - SPW'(3);
	assign dm_raddr = (head.op == CMD_LOAD) ? top_q[DAW-1:0] : DAW'(head.addr);
	assign top_ok   = top_q < 32'(MEMORY_WORDS);

	assign out_free     = !res_valid_q || !result_stall;
	assign commit       = (state_q == BS_EXEC) && out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BS_FETCH: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = BS_EXEC;
				end
			end
			BS_EXEC: begin
				if (out_free) begin
					state_d = BS_FETCH;
				end
			end
			default: state_d = BS_FETCH;
		endcase
	end

	always_comb begin
		sp_d     = sp_q;
		top_d    = top_q;
		skip_d   = skip_q;
		halt_d   = halt_q;
		err      = ERR_OK;
		skipped  = 1'b0;
		rd_val   = '0;
		st_we    = 1'b0;
		dm_we    = 1'b0;
		dm_waddr = DAW'(cmd_q.addr);
		dm_wdata = cmd_q.mval;
		case (cmd_q.op)
			CMD_MWRITE: begin
				if (cmd_q.addr_ok) begin
					dm_we = 1'b1;
				end else begin
					err = ERR_ADDR;
				end
			end
			CMD_MREAD: begin
				if (cmd_q.addr_ok) begin
					rd_val = dm_rd_q;
				end else begin
					err = ERR_ADDR;
				end
			end
			CMD_NONE: begin
				err = ERR_OK;
			end
			default: begin
				if (halt_q) begin
					err = ERR_HALTED;
				end else if (skip_q != '0) begin
					skip_d  = skip_q - SKIP_W'(1);
					skipped = 1'b1;
				end else begin
					case (cmd_q.op)
						CMD_ADD, CMD_NOR: begin
							if (sp_q < SPW'(2)) begin
								err = ERR_UNDER;
							end else begin
								top_d = (cmd_q.op == CMD_ADD) ? top_q + st_rd0_q
									: ~(top_q | st_rd0_q);
								sp_d  = sp_m1;
							end
						end
						CMD_IFZ: begin
							if (sp_q == '0) begin
								err = ERR_UNDER;
							end else begin
								sp_d  = sp_m1;
								top_d = st_rd0_q;
								if (top_q == '0 && !cmd_q.imm[WORD_W-1]) begin
									skip_d = cmd_q.imm[SKIP_W-1:0];
								end
							end
						end
						CMD_HALT: begin
							halt_d = 1'b1;
						end
						CMD_LOAD: begin
							if (sp_q == '0) begin
								err = ERR_UNDER;
							end else if (!top_ok) begin
								err = ERR_ADDR;
							end else begin
								top_d = dm_rd_q;
							end
						end
						CMD_STORE: begin
							if (sp_q < SPW'(2)) begin
								err = ERR_UNDER;
							end else if (!top_ok) begin
								err = ERR_ADDR;
							end else begin
								dm_we    = 1'b1;
								dm_waddr = top_q[DAW-1:0];
								dm_wdata = st_rd0_q;
								sp_d     = sp_m2;
								top_d    = st_rd1_q;
							end
						end
						CMD_POP: begin
							if (sp_q == '0) begin
								err = ERR_UNDER;
							end else begin
								sp_d  = sp_m1;
								top_d = st_rd0_q;
							end
						end
						CMD_PUSHI: begin
							if (sp_q >= SPW'(STACK_DEPTH)) begin
								err = ERR_OVER;
							end else begin
								// The old top moves down into the RAM.
								st_we = sp_q != '0;
								top_d = cmd_q.imm;
								sp_d  = sp_q + SPW'(1);
							end
						end
						default: begin
							err = ERR_OK;
						end
					endcase
				end
			end
		endcase

		res_d.top_value   = (sp_d == '0) ? '0 : top_d;
		res_d.stack_count = COUNT_W'(sp_d);
		res_d.is_halted   = halt_d;
		res_d.was_skipped = skipped;
		res_d.error_code  = err;
		res_d.read_value  = rd_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_FETCH;
			sp_q        <= '0;
			skip_q      <= '0;
			halt_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				sp_q        <= sp_d;
				skip_q      <= skip_d;
				halt_q      <= halt_d;
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (commit) begin
			top_q <= top_d;
			res_q <= res_d;
		end
	end

	// Stack RAM: two registered reads at fetch, one write at execute.
	always_ff @(posedge clk) begin
		if (commit && st_we) begin
			stack_mem[sp_m1[SAW-1:0]] <= top_q;
		end
		if (pop) begin
			st_rd0_q <= stack_mem[sp_m2[SAW-1:0]];
			st_rd1_q <= stack_mem[sp_m3[SAW-1:0]];
		end
	end

	// Data memory: registered read at fetch, write at execute.
	always_ff @(posedge clk) begin
		if (commit && dm_we) begin
			data_mem[dm_waddr] <= dm_wdata;
		end
		if (pop) begin
			dm_rd_q <= data_mem[dm_raddr];
		end
	end

endmodule

// ===== design/stack_machine_executor_unit.sv =====
// Top level of the stack machine executor: front end, command queue and back end.
//
//   Channel  Direction  Handshake                    Payload
//   instr    in         instr_valid / instr_stall    in_t  (kind, opcode, operands)
//   result   out        result_valid / result_stall  out_t (stack view, flags, error)
//
// Every item passes through the back end's fetch and execute states: fetch reads the
// two stack entries below the cached top and the data memory word, execute executes
// and writes back. A new item is taken only after the last one has executed, as set
// by the read-then-execute sequence around the stack RAM ports.
// Reset clears the stack pointer, skip counter, halted flag and all valid state;
// the stack RAM and data memory are not cleared.
// A stalled result holds the back end, and a full queue then stalls the input.

module stack_machine_executor_unit import sme_pkg::*; #(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic instr_valid,
	output logic instr_stall,
	input  in_t  instr,
	output logic result_valid,
	input  logic result_stall,
	output out_t result
);

	// Decoded commands leave the front end here.
	logic push;
	cmd_t push_data;
	logic q_full;

	// Queue head as seen by the back end.
	logic head_valid;
	cmd_t head;
	logic pop;

	// The front end decodes each transfer and parks it in its own stage register,
	// so a stalled back end never blocks decode until the queue is full.
	sme_front #(
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr      (instr),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// The queue lets both halves stall independently.
	sme_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// The back end owns all machine state and the result register.
	sme_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ===== design/sme_check.sv =====
// Port-level checker for the stack machine executor, bound to the top level.
module sme_check import sme_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic instr_valid,
	input logic instr_stall,
	input logic result_valid,
	input logic result_stall,
	input out_t result
);

	logic [3:0] pend_q;
	logic       halt_seen_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = instr_valid && !instr_stall;
	assign out_xfer = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			halt_seen_q <= 1'b0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
			if (out_xfer && result.is_halted) begin
				halt_seen_q <= 1'b1;
			end
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 4'd0)
		else $error("result transfer without an outstanding input item");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && halt_seen_q |-> result.is_halted)
		else $error("halted flag dropped after a halt");

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.was_skipped |->
			result.error_code == ERR_OK && result.read_value == '0)
		else $error("skipped instruction reported an error or read data");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stack_count == '0 |-> result.top_value == '0)
		else $error("empty stack with nonzero top value");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

endmodule

bind stack_machine_executor_unit sme_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.instr_valid (instr_valid),
	.instr_stall (instr_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
